// ===== sv/fp32_round_to_half_precision_top_assert.svh =====
// ----------------------------------------------------------------------------
// fp32 half round trip assertion macros
// Shared concurrent assertion forms for the RTL.
// ----------------------------------------------------------------------------
`ifndef FP32_ROUND_TO_HALF_PRECISION_TOP_ASSERT_SVH
`define FP32_ROUND_TO_HALF_PRECISION_TOP_ASSERT_SVH

// implication checked every cycle outside reset
`define FRH_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: lbl");

// implication checked on the following cycle
`define FRH_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: lbl");

`endif

// ===== sv/frh_pkg.sv =====
// ----------------------------------------------------------------------------
// frh_pkg
// Types and constants for the fp32 half-precision round trip.
// ----------------------------------------------------------------------------
`default_nettype none
package frh_pkg;

  typedef struct packed {
    logic [31:0] in_bits;
    logic        in_last;
  } in_item_t;

  typedef struct packed {
    logic [31:0] out_bits;
    logic        out_last;
  } out_item_t;

  typedef struct packed {
    logic clamp_enable;
    logic flush_enable;
  } cfg_t;

  localparam logic CfgClamp = 1'b0;
  localparam logic CfgFlush = 1'b1;

  localparam logic [31:0] F32Abs     = 32'h7FFF_FFFF;
  localparam logic [31:0] F32ExpAll  = 32'h7F80_0000;
  localparam logic [31:0] F32MaxHalf = 32'h477F_E000;
  localparam logic [31:0] F32Tiny    = 32'h3880_0000;

endpackage
`default_nettype wire

// ===== sv/frh_core.sv =====
// ----------------------------------------------------------------------------
// frh_core
// Combinational fp32 -> fp16 (RNE) -> fp32 with clamp and flush.
// ----------------------------------------------------------------------------
`default_nettype none
module frh_core (
  input  wire logic [31:0]   bits_i,
  input  wire frh_pkg::cfg_t cfg,
  output logic [31:0]        bits_o
);
  import frh_pkg::*;

  logic        s;
  logic [7:0]  e;
  logic [22:0] m;
  logic [14:0] h;
  logic [23:0] sig;
  logic [24:0] shv;
  logic [4:0]  sh;
  logic [23:0] rem;
  logic [23:0] halfway;
  logic [10:0] hs;
  logic [31:0] r;
  logic [4:0]  he;
  logic [9:0]  hm;
  logic [3:0]  lz;
  logic [9:0]  nm;
  logic        is_nan;

  always_comb begin
    s = bits_i[31];
    e = bits_i[30:23];
    m = bits_i[22:0];
    sig = {1'b1, m};
    sh = 5'(8'd126 - e);
    shv = {1'b0, sig} >> sh;
    hs = shv[10:0];
    rem = sig & ((24'd1 << sh) - 24'd1);
    halfway = 24'd1 << (sh - 5'd1);
    h = '0;
    if (e == 8'hFF) begin
      h = (m == '0) ? 15'h7C00 : (15'h7E00 | 15'(m[22:13]));
    end else if (e >= 8'd143) begin
      h = 15'h7C00;
    end else if (e >= 8'd113) begin
      h = {5'(e - 8'd112), m[22:13]};
      if (m[12:0] > 13'h1000 || (m[12:0] == 13'h1000 && h[0]))
        h = h + 15'd1;
    end else if (e == 8'd0 || e < 8'd102) begin
      h = '0;
    end else begin
      h = 15'(hs);
      if (rem > halfway || (rem == halfway && hs[0]))
        h = h + 15'd1;
    end
    he = h[14:10];
    hm = h[9:0];
    lz = 4'd0;
    for (int i = 9; i >= 0; i--) begin
      if (hm[i] && lz == 4'd0) lz = 4'(10 - i);
    end
    nm = 10'(hm << lz);
    if (he == 5'd31)
      r = {s, 8'hFF, hm, 13'd0};
    else if (he == 5'd0)
      r = (hm == '0) ? {s, 31'd0} : {s, 8'(8'd113 - 8'(lz)), nm, 13'd0};
    else
      r = {s, 8'(he) + 8'd112, hm, 13'd0};
    is_nan = (r & F32Abs) > F32ExpAll;
    if (cfg.clamp_enable && !is_nan && (r & F32Abs) > F32MaxHalf)
      r = {r[31], F32MaxHalf[30:0]};
    if (cfg.flush_enable && !is_nan && (r & F32Abs) < F32Tiny)
      r = '0;
    bits_o = r;
  end
endmodule
`default_nettype wire

// ===== sv/fp32_round_to_half_precision_top.sv =====
// Input register, then result register around one combinational conversion
// stage; a stall on out_ready can hold a transaction between the two.
// One transaction per cycle unless out_ready stalls; rounding is a single pass.
// Reset: rst (synchronous) empties both stages and clears clamp/flush to 0.
// ----------------------------------------------------------------------------
// fp32_round_to_half_precision_top
// Streams fp32 words through a half-precision RNE round trip.
// ----------------------------------------------------------------------------
`default_nettype none
`include "fp32_round_to_half_precision_top_assert.svh"
module fp32_round_to_half_precision_top (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire frh_pkg::in_item_t in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output frh_pkg::out_item_t     out_data,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic              cfg_index,
  input  wire logic              cfg_data
);
  import frh_pkg::*;

  cfg_t        cfg;
  in_item_t    in_reg;
  logic        in_reg_valid;
  logic [31:0] conv;
  logic        adv;

  assign cfg_ready = 1'b1;
  assign adv       = !out_valid || out_ready;
  assign in_ready  = !in_reg_valid || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CfgClamp: cfg.clamp_enable <= cfg_data;
        CfgFlush: cfg.flush_enable <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_reg_valid <= 1'b0;
    end else if (in_ready) begin
      in_reg_valid <= in_valid;
    end
    if (in_ready && in_valid) in_reg <= in_data;
  end

  frh_core u_core (
    .bits_i (in_reg.in_bits),
    .cfg    (cfg),
    .bits_o (conv)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= in_reg_valid;
    end
    if (adv && in_reg_valid) out_data <= '{out_bits: conv, out_last: in_reg.in_last};
  end

  `FRH_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))
  `FRH_ASSERT_NEXT(a_fill, in_reg_valid && adv, out_valid)
  `FRH_ASSERT_IMP(a_ready, !in_ready, in_reg_valid && out_valid)
endmodule
`default_nettype wire
